[rtl/core/wrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrm_pkg: shared types and constants for the windowed rate meter
// Holds the word structs, command codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam int Depth      = 16;
  localparam int SlotBits   = $clog2(Depth);
  localparam int FillBits   = $clog2(Depth + 1);
  localparam int SampleBits = 32;
  localparam int TimeBits   = 32;
  localparam int WinBits    = 16;
  localparam int ValBits    = 64;
  localparam int CfgBits    = 5;
  localparam int MsPerSec   = 1000;

  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_WINDOW   = 3'd1;
  localparam logic [2:0] CMD_LIFETIME = 3'd2;
  localparam logic [2:0] CMD_TOTAL    = 3'd3;
  localparam logic [2:0] CMD_ELAPSED  = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;

  localparam logic [1:0] KIND_WINDOW   = 2'd0;
  localparam logic [1:0] KIND_LIFETIME = 2'd1;
  localparam logic [1:0] KIND_TOTAL    = 2'd2;
  localparam logic [1:0] KIND_ELAPSED  = 2'd3;

  typedef struct packed {
    logic [2:0]            command;
    logic [SampleBits-1:0] sample_value;
    logic [WinBits-1:0]    window_sec;
    logic [TimeBits-1:0]   now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [ValBits-1:0] result_value;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input word
    logic add;      // store sample
    logic clear;    // clear history
    logic cfg_load; // take new depth
    logic scan_init;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic mul_step;  // apply *1000 after divide
    logic set_out;   // load output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic need_div;
    logic need_mul;
  } sts_t;

endpackage

[rtl/core/wrm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrm_ctrl: sequencer for the windowed rate meter
// Steps a query through capture, slot scan, any divide and result hand-off.
// ----------------------------------------------------------------------------
module wrm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [2:0]    in_command,
  input  logic          cfg_write,
  input  logic          out_busy,
  input  wrm_pkg::sts_t sts,
  output logic          in_stall,
  output logic          out_load,
  output wrm_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_PREP, S_DIV, S_MUL, S_OUT
  } state_t;
  state_t state;
  logic [2:0] cmd;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl = '0;
    out_load = 1'b0;
    ctl.load = (state == S_IDLE) && in_valid;
    ctl.clear = cfg_write;
    ctl.cfg_load = cfg_write;
    case (state)
      S_DECODE: begin
        if (cmd == wrm_pkg::CMD_ADD) ctl.add = 1'b1;
        else if (cmd == wrm_pkg::CMD_WINDOW) ctl.scan_init = 1'b1;
        else if (cmd > wrm_pkg::CMD_ELAPSED) ctl.clear = 1'b1;
        else ctl.scan_init = 1'b1;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_done) ctl.div_start = 1'b1;
      end
      S_DIV: ctl.div_step = 1'b1;
      S_MUL: ctl.mul_step = 1'b1;
      S_OUT: begin
        ctl.set_out = !out_busy;
        out_load = !out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          cmd <= in_command;
          state <= S_DECODE;
        end
        S_DECODE: begin
          if (cmd == wrm_pkg::CMD_ADD || cmd > wrm_pkg::CMD_ELAPSED) state <= S_IDLE;
          else state <= S_SCAN;
        end
        S_SCAN: if (sts.scan_done) state <= S_PREP;
        // divide flags are registered at the end of the scan
        S_PREP: state <= sts.need_div ? S_DIV : S_OUT;
        S_DIV: if (sts.div_done) state <= sts.need_mul ? S_MUL : S_OUT;
        S_MUL: state <= S_OUT;
        S_OUT: if (!out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/wrm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrm_datapath: history store, scan accumulator and serial divider
// Scans one slot a cycle, then divides one quotient bit a cycle.
// ----------------------------------------------------------------------------
module wrm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  wrm_pkg::ctl_t                 ctl,
  input  wrm_pkg::in_word_t             in_word,
  input  logic [wrm_pkg::CfgBits-1:0]   cfg_data,
  output wrm_pkg::sts_t                 sts,
  output wrm_pkg::out_word_t            out_word
);

  localparam int SB = wrm_pkg::SlotBits;
  localparam int FB = wrm_pkg::FillBits;
  localparam int TB = wrm_pkg::TimeBits;
  localparam int VB = wrm_pkg::ValBits;

  logic [wrm_pkg::SampleBits-1:0] sample_store [wrm_pkg::Depth];
  logic [TB-1:0]                  time_store [wrm_pkg::Depth];
  logic [wrm_pkg::Depth-1:0]      sample_ok;
  logic [SB-1:0]  write_slot;
  logic [FB-1:0]  fill_count;
  logic [FB-1:0]  depth_in_use;
  logic [VB-1:0]  running_total;
  logic [TB-1:0]  first_time;

  wrm_pkg::in_word_t cur;
  logic [FB-1:0]  idx;
  logic [VB-1:0]  sum;
  logic [TB-1:0]  span;
  logic [TB-1:0]  newest;
  logic [TB+10-1:0] limit;
  logic [VB-1:0]  quo;
  logic [TB:0]    rem;
  logic [VB-1:0]  dvd;
  logic [TB-1:0]  dvs;
  logic [6:0]     dcnt;
  logic [1:0]     kind;
  logic [VB-1:0]  value;
  logic           need_div;
  logic           need_mul;

  logic [FB-1:0]  cfg_sat;
  logic [SB-1:0]  last_slot;
  logic [TB-1:0]  slot_time;
  logic [wrm_pkg::SampleBits-1:0] slot_sample;
  logic [TB-1:0]  age;
  logic [TB-1:0]  elapsed;
  logic [TB:0]    rem_sh;
  logic [FB-1:0]  wnext;

  assign cfg_sat = (cfg_data > FB'(wrm_pkg::Depth)) ? FB'(wrm_pkg::Depth) : FB'(cfg_data);
  assign last_slot = (write_slot == '0) ? SB'(depth_in_use - FB'(1)) : write_slot - SB'(1);
  assign slot_time = time_store[idx[SB-1:0]];
  assign slot_sample = sample_ok[idx[SB-1:0]] ? sample_store[idx[SB-1:0]] : '0;
  assign age = (cur.window_sec == '0) ? newest - slot_time : cur.now_ms - slot_time;
  assign elapsed = cur.now_ms - first_time;
  assign rem_sh = {rem[TB-1:0], dvd[VB-1]};
  assign wnext = FB'(write_slot) + FB'(1);

  assign sts.scan_done = (idx >= fill_count);
  assign sts.div_done = (dcnt == 7'(VB - 1));
  assign sts.need_div = need_div;
  assign sts.need_mul = need_mul;

  always_ff @(posedge clk) begin
    if (ctl.add && depth_in_use != '0) begin
      sample_store[write_slot] <= cur.sample_value;
      time_store[write_slot] <= cur.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_ok <= '0;
      write_slot <= '0;
      fill_count <= '0;
      depth_in_use <= FB'(wrm_pkg::Depth);
      running_total <= '0;
      first_time <= '0;
    end else if (ctl.clear) begin
      sample_ok <= '0;
      write_slot <= '0;
      fill_count <= '0;
      running_total <= '0;
      first_time <= '0;
    end else if (ctl.add && depth_in_use != '0) begin
      sample_ok[write_slot] <= 1'b1;
      if (fill_count == '0) first_time <= cur.now_ms;
      if (fill_count < depth_in_use) fill_count <= fill_count + FB'(1);
      write_slot <= (wnext >= depth_in_use) ? '0 : SB'(wnext);
      running_total <= running_total + VB'(cur.sample_value);
    end
    if (!rst && ctl.cfg_load)
      depth_in_use <= cfg_sat;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) cur <= in_word;
    if (ctl.scan_init) begin
      idx <= '0;
      sum <= '0;
      span <= '0;
      newest <= time_store[last_slot];
      limit <= (TB+10)'(cur.window_sec) * (TB+10)'(wrm_pkg::MsPerSec);
      case (cur.command)
        wrm_pkg::CMD_WINDOW:   kind <= wrm_pkg::KIND_WINDOW;
        wrm_pkg::CMD_LIFETIME: kind <= wrm_pkg::KIND_LIFETIME;
        wrm_pkg::CMD_TOTAL:    kind <= wrm_pkg::KIND_TOTAL;
        default:               kind <= wrm_pkg::KIND_ELAPSED;
      endcase
      if (cur.command != wrm_pkg::CMD_WINDOW) idx <= fill_count;
    end else if (ctl.scan_step && !sts.scan_done) begin
      idx <= idx + FB'(1);
      sum <= sum + VB'(slot_sample);
      if (cur.window_sec == '0) begin
        if (age > span) span <= age;
      end else if ((TB+10)'(age) > limit) begin
        sum <= sum;
      end
    end
    if (ctl.div_start) begin
      need_div <= 1'b1;
      need_mul <= 1'b0;
      dcnt <= '0;
      rem <= '0;
      quo <= '0;
      value <= '0;
      case (cur.command)
        wrm_pkg::CMD_WINDOW: begin
          dvd <= sum;
          if (cur.window_sec != '0) dvs <= TB'(cur.window_sec);
          else begin
            dvs <= span;
            need_mul <= 1'b1;
            need_div <= (span != '0) && (depth_in_use != '0);
          end
        end
        wrm_pkg::CMD_LIFETIME: begin
          dvd <= running_total;
          dvs <= elapsed;
          need_mul <= 1'b1;
          need_div <= elapsed != '0;
        end
        wrm_pkg::CMD_TOTAL: begin
          need_div <= 1'b0;
          value <= running_total;
        end
        default: begin
          need_div <= 1'b0;
          value <= (fill_count == '0) ? '0 : VB'(elapsed);
        end
      endcase
    end else if (ctl.div_step) begin
      dcnt <= dcnt + 7'd1;
      dvd <= {dvd[VB-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        quo <= {quo[VB-2:0], 1'b1};
        value <= {quo[VB-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[VB-2:0], 1'b0};
        value <= {quo[VB-2:0], 1'b0};
      end
    end else if (ctl.mul_step) begin
      // x1000 as 1024 - 16 - 8
      value <= (value << 10) - (value << 4) - (value << 3);
    end
    if (ctl.set_out) begin
      out_word.result_kind <= kind;
      out_word.result_value <= value;
    end
  end

endmodule

[rtl/core/windowed_rate_meter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rate_meter_unit: sliding-window rate meter over timestamped samples
// Top level joining the sequencer, the history datapath and the output word.
// ----------------------------------------------------------------------------
// One word at a time. An add or clear is captured and then decoded. A query
// is captured and decoded; a windowed-rate query then scans one filled history
// slot per cycle while other queries pass the scan state without stepping. A
// state picks the path; when a division is needed the bit-serial 64/32 divider
// runs, followed by the *1000 scale for rates over a millisecond span. Last the
// output register is loaded. Configuration writes must come while no word is
// in flight; they clear the history.
module windowed_rate_meter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  wrm_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output wrm_pkg::out_word_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wrm_pkg::CfgBits-1:0] cfg_data
);

  wrm_pkg::ctl_t ctl;
  wrm_pkg::sts_t sts;
  logic          out_load;
  logic          cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid;

  wrm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .cfg_write  (cfg_write),
    .out_busy   (out_valid && out_stall),
    .sts        (sts),
    .in_stall   (in_stall),
    .out_load   (out_load),
    .ctl        (ctl)
  );

  wrm_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .in_word  (in_data),
    .cfg_data (cfg_data),
    .sts      (sts),
    .out_word (out_data)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for windowed_rate_meter_unit
// Sends directed and random command words, predicts every query result from a
// behavioral copy of the history ring and compares results in order.
// ----------------------------------------------------------------------------
module tb;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  wrm_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  wrm_pkg::out_word_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [wrm_pkg::CfgBits-1:0] cfg_data;

  windowed_rate_meter_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  localparam longint CycleLimit = 2000000;
  localparam int     HoldLen    = 3000;

  // predictor state
  logic [wrm_pkg::SampleBits-1:0] hist_sample [wrm_pkg::Depth];
  logic [wrm_pkg::TimeBits-1:0]   hist_time [wrm_pkg::Depth];
  int unsigned                    slot_ptr;
  int unsigned                    filled;
  logic [63:0]                    lifetime_sum;
  logic [wrm_pkg::TimeBits-1:0]   start_ms;
  int unsigned                    slots_used;

  wrm_pkg::out_word_t pending_results[$];
  int        mismatches;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;
  int        hold_seq;
  int        hold_seen;
  longint    cycle_count;
  logic [wrm_pkg::TimeBits-1:0] clock_ms;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall, with a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_cycles <= 0;
      hold_seen   <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_cycles <= HoldLen;
      out_stall   <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    wrm_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word kind=%0d value=%0d",
                   out_data.result_kind, out_data.result_value);
      end else begin
        want = pending_results.pop_front();
        if (want.result_kind !== out_data.result_kind ||
            want.result_value !== out_data.result_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind=%0d value=%0d, got kind=%0d value=%0d",
                     want.result_kind, want.result_value,
                     out_data.result_kind, out_data.result_value);
        end
      end
    end
  end

  function automatic void clear_meter();
    for (int i = 0; i < wrm_pkg::Depth; i++) hist_sample[i] = '0;
    slot_ptr     = 0;
    filled       = 0;
    lifetime_sum = '0;
    start_ms     = '0;
  endfunction

  function automatic logic [63:0] window_rate(logic [15:0] win, logic [31:0] now);
    logic [63:0] sum;
    logic [63:0] limit;
    logic [63:0] span;
    logic [31:0] newest;
    logic [31:0] age;
    int unsigned last;
    sum = 0;
    span = 0;
    if (win != 0) begin
      limit = 64'(win) * 64'(wrm_pkg::MsPerSec);
      for (int i = 0; i < filled; i++) begin
        age = now - hist_time[i];
        if (64'(age) <= limit) sum += 64'(hist_sample[i]);
      end
      return sum / 64'(win);
    end
    if (filled == 0 || slots_used == 0) return 64'd0;
    last = (slot_ptr == 0 ? slots_used : slot_ptr) - 1;
    if (last >= wrm_pkg::Depth) last = wrm_pkg::Depth - 1;
    newest = hist_time[last];
    for (int i = 0; i < filled; i++) begin
      age = newest - hist_time[i];
      sum += 64'(hist_sample[i]);
      if (64'(age) > span) span = 64'(age);
    end
    if (span == 0) return 64'd0;
    return (sum / span) * 64'(wrm_pkg::MsPerSec);
  endfunction

  function automatic void predict_word(wrm_pkg::in_word_t w);
    wrm_pkg::out_word_t r;
    logic [31:0] elapsed;
    elapsed = w.now_ms - start_ms;
    case (w.command)
      wrm_pkg::CMD_ADD: begin
        if (slots_used != 0) begin
          hist_sample[slot_ptr] = w.sample_value;
          hist_time[slot_ptr]   = w.now_ms;
          if (filled == 0) start_ms = w.now_ms;
          if (filled < slots_used) filled++;
          slot_ptr = (slot_ptr + 1) % slots_used;
          lifetime_sum += 64'(w.sample_value);
        end
      end
      wrm_pkg::CMD_WINDOW: begin
        r.result_kind  = wrm_pkg::KIND_WINDOW;
        r.result_value = window_rate(w.window_sec, w.now_ms);
        pending_results.push_back(r);
      end
      wrm_pkg::CMD_LIFETIME: begin
        r.result_kind  = wrm_pkg::KIND_LIFETIME;
        r.result_value = elapsed == 0 ? 64'd0 :
                         (lifetime_sum / 64'(elapsed)) * 64'(wrm_pkg::MsPerSec);
        pending_results.push_back(r);
      end
      wrm_pkg::CMD_TOTAL: begin
        r.result_kind  = wrm_pkg::KIND_TOTAL;
        r.result_value = lifetime_sum;
        pending_results.push_back(r);
      end
      wrm_pkg::CMD_ELAPSED: begin
        r.result_kind  = wrm_pkg::KIND_ELAPSED;
        r.result_value = filled == 0 ? 64'd0 : 64'(elapsed);
        pending_results.push_back(r);
      end
      default: clear_meter();
    endcase
  endfunction

  // leaves valid high after the accept; the next send replaces the word, drain drops valid
  task automatic send_word(logic [2:0] cmd, logic [31:0] sample, logic [15:0] win,
                           logic [31:0] now);
    wrm_pkg::in_word_t w;
    w.command      = cmd;
    w.sample_value = sample;
    w.window_sec   = win;
    w.now_ms       = now;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    predict_word(w);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a trailing add or clear may still be in flight
    repeat (100) @(posedge clk);
  endtask

  task automatic write_depth(logic [wrm_pkg::CfgBits-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slots_used = value > wrm_pkg::Depth ? wrm_pkg::Depth : value;
    clear_meter();
  endtask

  // time advances mostly in small steps so windows catch some samples
  function automatic logic [31:0] next_ms();
    case ($urandom_range(9))
      0:       clock_ms = $urandom;
      1:       clock_ms = clock_ms;
      2, 3:    clock_ms = clock_ms + $urandom_range(200000);
      default: clock_ms = clock_ms + $urandom_range(3000);
    endcase
    return clock_ms;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(100000);
    endcase
  endfunction

  function automatic logic [15:0] rand_window();
    case ($urandom_range(4))
      0:       return 16'd0;
      1:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic random_words(int count);
    logic [2:0] cmd;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0:                   cmd = 3'($urandom_range(wrm_pkg::CMD_CLEAR, 7));
        1, 2, 3, 4, 5, 6, 7: cmd = wrm_pkg::CMD_ADD;
        default: cmd = 3'($urandom_range(wrm_pkg::CMD_WINDOW, wrm_pkg::CMD_ELAPSED));
      endcase
      send_word(cmd, rand_sample(), rand_window(), next_ms());
    end
  endtask

  task automatic test_directed();
    send_word(wrm_pkg::CMD_ELAPSED, 32'd0, 16'd0, 32'd5);
    send_word(wrm_pkg::CMD_WINDOW, 32'd0, 16'd0, 32'd5);
    send_word(wrm_pkg::CMD_LIFETIME, 32'd0, 16'd0, 32'd0);
    send_word(wrm_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFF0);
    send_word(wrm_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0010);
    send_word(wrm_pkg::CMD_TOTAL, 32'd0, 16'd0, 32'd0);
    send_word(wrm_pkg::CMD_WINDOW, 32'd0, 16'd1, 32'h0000_0020);
    send_word(wrm_pkg::CMD_WINDOW, 32'd0, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(wrm_pkg::CMD_WINDOW, 32'd0, 16'd0, 32'h0000_0020);
    send_word(wrm_pkg::CMD_LIFETIME, 32'd0, 16'd0, 32'h0000_0020);
    send_word(wrm_pkg::CMD_LIFETIME, 32'd0, 16'd0, 32'hFFFF_FFF0);
    send_word(wrm_pkg::CMD_ELAPSED, 32'd0, 16'd0, 32'h0000_0100);
    send_word(wrm_pkg::CMD_CLEAR, 32'd0, 16'd0, 32'd0);
    send_word(wrm_pkg::CMD_ADD, 32'd7, 16'd0, 32'd100);
    send_word(wrm_pkg::CMD_ADD, 32'd9, 16'd0, 32'd100);
    send_word(wrm_pkg::CMD_WINDOW, 32'd0, 16'd0, 32'd100);
    send_word(wrm_pkg::CMD_CLEAR, 32'd0, 16'd0, 32'd0);
    send_word(wrm_pkg::CMD_TOTAL, 32'd0, 16'd0, 32'd0);
    send_word(wrm_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 18; i++)
      send_word(wrm_pkg::CMD_ADD, 32'(i + 1), 16'd0, 32'(1000 * i));
    send_word(wrm_pkg::CMD_WINDOW, 32'd0, 16'd0, 32'd20000);
    send_word(wrm_pkg::CMD_WINDOW, 32'd0, 16'd5, 32'd17000);
  endtask

  task automatic test_depths();
    write_depth(5'd0);
    send_word(wrm_pkg::CMD_ADD, 32'd50, 16'd0, 32'd10);
    send_word(wrm_pkg::CMD_WINDOW, 32'd0, 16'd0, 32'd20);
    send_word(wrm_pkg::CMD_ELAPSED, 32'd0, 16'd0, 32'd20);
    write_depth(5'd1);
    random_words(60);
    write_depth(5'd31);
    random_words(60);
    write_depth(5'd3);
    random_words(80);
    write_depth(5'd16);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq++;
    random_words(40);
    drain();
    // a second burst, then the sender waits for every result
    random_words(20);
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    out_stall     = 1'b0;
    hold_seq      = 0;
    cycle_count   = 0;
    mismatches    = 0;
    clock_ms      = $urandom;
    send_idle_pct = 37;
    recv_idle_pct = 68;
    slots_used    = wrm_pkg::Depth;
    for (int i = 0; i < wrm_pkg::Depth; i++) hist_time[i] = '0;
    clear_meter();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_depths();
    random_words(350);
    send_idle_pct = 68;
    recv_idle_pct = 37;
    random_words(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_words(300);
    test_backpressure();
    drain();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/wrm_pkg.sv
rtl/core/wrm_ctrl.sv
rtl/core/wrm_datapath.sv
rtl/core/windowed_rate_meter_unit.sv
bench/tb.sv
